>>> src/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, constants and helper functions of the UTF-8 stream validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

  localparam int unsigned OffsetW = 17;
  localparam logic [OffsetW-1:0] MaxRunBytes = 17'd65536;

  // Verdict codes carried with every result transaction
  typedef enum logic [1:0] {
    StPending = 2'd0,
    StValid   = 2'd1,
    StInvalid = 2'd2,
    StDrain   = 2'd3
  } status_e;

  // Per-run state kept between bytes
  typedef struct packed {
    logic [1:0]         bytes_left;
    logic [7:0]         lead_value;
    logic [7:0]         second_value;
    logic [7:0]         third_value;
    logic [OffsetW-1:0] seq_start;
    logic [OffsetW-1:0] position;
    logic               failed;
  } run_state_t;

  // Result of one byte
  typedef struct packed {
    status_e            status;
    logic [OffsetW-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [1:0] cont_cnt;
  } lead_t;

  function automatic logic [OffsetW-1:0] sat_inc(input logic [OffsetW-1:0] v);
    logic [OffsetW-1:0] r;
    if (v >= MaxRunBytes) r = MaxRunBytes;
    else                  r = v + 1'b1;
    return r;
  endfunction

  function automatic lead_t lead_class(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b inside {[8'h00:8'h7F]})      r.cont_cnt = 2'd0;
    else if (b inside {[8'hC2:8'hDF]}) r.cont_cnt = 2'd1;
    else if (b inside {[8'hE0:8'hEF]}) r.cont_cnt = 2'd2;
    else if (b inside {[8'hF0:8'hF4]}) r.cont_cnt = 2'd3;
    else                               r.bad = 1'b1;
    return r;
  endfunction

  // Continuation byte check against the open sequence
  function automatic logic cont_ok(input logic [7:0] c, input run_state_t st);
    logic ok;
    ok = 1'b1;
    if (!(c inside {[8'h80:8'hBF]})) ok = 1'b0;
    else if (st.bytes_left == 2'd0) ok = 1'b0;
    else if (st.lead_value >= 8'hF0) begin
      if (st.bytes_left == 2'd3) begin
        if (st.lead_value == 8'hF0 && c < 8'h90) ok = 1'b0;
        if (st.lead_value == 8'hF4 && c > 8'h8F) ok = 1'b0;
      end else if (st.bytes_left == 2'd1) begin
        // plane-final noncharacters xFFFE / xFFFF
        if ((c == 8'hBF || c == 8'hBE) && st.third_value == 8'hBF &&
            (st.second_value & 8'h8F) == 8'h8F) ok = 1'b0;
      end
    end else if (st.lead_value >= 8'hE0) begin
      if (st.bytes_left == 2'd2) begin
        if (st.lead_value == 8'hE0 && c < 8'hA0) ok = 1'b0;
        if (st.lead_value == 8'hED && c > 8'h9F) ok = 1'b0;
      end else if (st.lead_value == 8'hEF) begin
        // U+FDD0..FDEF and U+FFFE/FFFF
        if (st.second_value == 8'hB7 && c > 8'h8F && c < 8'hB0) ok = 1'b0;
        if (st.second_value == 8'hBF && (c == 8'hBE || c == 8'hBF)) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> src/utf8v_in_if.sv
// ----------------------------------------------------------------------------
// utf8v_in_if
// Byte input channel: valid/ready handshake with one text byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> src/utf8v_out_if.sv
// ----------------------------------------------------------------------------
// utf8v_out_if
// Result channel: valid/ready handshake with status and end offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [utf8v_pkg::OffsetW-1:0]   end_offset;

  modport source (output valid, output status, output end_offset, input ready);
  modport sink   (input valid, input status, input end_offset, output ready);
endinterface

`default_nettype wire

>>> src/utf8v_check.sv
// ----------------------------------------------------------------------------
// utf8v_check
// Per-byte decode: next run state and result for one byte, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_check (
  input  utf8v_pkg::run_state_t st_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  zero_term_i,
  output utf8v_pkg::run_state_t st_o,
  output utf8v_pkg::result_t    res_o
);

  logic                             run_end;
  logic                             error;
  logic                             valid_end;
  logic [utf8v_pkg::OffsetW-1:0]    pos_inc;
  utf8v_pkg::lead_t                 lead;
  utf8v_pkg::run_state_t            st_n;
  logic [1:0]                       left_n;

  assign run_end = zero_term_i ? (data_byte_i == 8'h00) : last_byte_i;
  assign pos_inc = utf8v_pkg::sat_inc(st_i.position);
  assign lead    = utf8v_pkg::lead_class(data_byte_i);
  assign left_n  = st_i.bytes_left - 2'd1;

  always_comb begin
    st_n             = st_i;
    error            = 1'b0;
    valid_end        = 1'b0;
    res_o.status     = utf8v_pkg::StPending;
    res_o.end_offset = '0;

    if (st_i.failed) begin
      res_o.status = utf8v_pkg::StDrain;
      if (run_end) st_n = '0;
      else         st_n.position = pos_inc;
    end else begin
      if (st_i.bytes_left == 2'd0) begin
        st_n.seq_start = st_i.position;
        if (data_byte_i == 8'h00) begin
          if (zero_term_i) begin
            valid_end        = 1'b1;
            res_o.end_offset = st_i.position;
          end else begin
            error = 1'b1;
          end
        end else if (lead.bad) begin
          error = 1'b1;
        end else if (lead.cont_cnt == 2'd0) begin
          if (run_end) begin
            valid_end        = 1'b1;
            res_o.end_offset = pos_inc;
          end
        end else begin
          st_n.lead_value   = data_byte_i;
          st_n.second_value = '0;
          st_n.third_value  = '0;
          st_n.bytes_left   = lead.cont_cnt;
          if (run_end) error = 1'b1;
        end
      end else if (!utf8v_pkg::cont_ok(data_byte_i, st_i)) begin
        error = 1'b1;
      end else begin
        if (st_i.lead_value >= 8'hF0) begin
          if (st_i.bytes_left == 2'd3)      st_n.second_value = data_byte_i;
          else if (st_i.bytes_left == 2'd2) st_n.third_value  = data_byte_i;
        end else if (st_i.lead_value >= 8'hE0) begin
          if (st_i.bytes_left == 2'd2) st_n.second_value = data_byte_i;
        end
        st_n.bytes_left = left_n;
        if (run_end) begin
          if (left_n != 2'd0) begin
            error = 1'b1;
          end else begin
            valid_end        = 1'b1;
            res_o.end_offset = pos_inc;
          end
        end
      end

      if (error) begin
        res_o.status     = utf8v_pkg::StInvalid;
        res_o.end_offset = st_n.seq_start;
        if (run_end) begin
          st_n = '0;
        end else begin
          st_n.failed     = 1'b1;
          st_n.bytes_left = '0;
          st_n.position   = pos_inc;
        end
      end else if (valid_end) begin
        res_o.status = utf8v_pkg::StValid;
        st_n         = '0;
      end else begin
        st_n.position = pos_inc;
      end
    end
  end

  assign st_o = st_n;

endmodule

`default_nettype wire

>>> src/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator
// UTF-8 validator over a byte stream, one result per input byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the skid register is empty and returns one
// registered result per byte, via the skid register when the result register
// is held; the decode feeding the run state is combinational. Each result
// carries status (pending, run valid, run invalid, draining) and, on a run
// verdict, the end offset or the start of the failing sequence, saturating
// at 65536. A two-deep output stage (result register plus skid register)
// keeps input accepted while one result waits downstream. The mode
// register zero_terminated should be written only while the block is idle.
`default_nettype none

module utf8_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  utf8v_in_if.sink    in_i,
  utf8v_out_if.source out_o
);

  logic                  zero_term_q;
  utf8v_pkg::run_state_t state_q, state_d;
  utf8v_pkg::result_t    result;
  utf8v_pkg::result_t    out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;
  logic                  in_fire, out_fire;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  utf8v_check u_check (
    .st_i        (state_q),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .zero_term_i (zero_term_q),
    .st_o        (state_d),
    .res_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_term_q  <= 1'b0;
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) zero_term_q <= cfg_wdata_i;
      if (in_fire)  state_q     <= state_d;

      if (out_fire || !out_valid_q) begin
        // output slot frees up: skid drains first, else take the new result
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_fire) out_q <= result;
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_q.status;
  assign out_o.end_offset = out_q.end_offset;

  // skid register only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a transaction with no result ahead");

  // draining state never keeps an open sequence
  a_drain_no_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.failed |-> (state_q.bytes_left == 2'd0))
    else $error("draining with continuation bytes still expected");

  // entering the drain state is announced by an invalid verdict
  a_fail_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !state_q.failed && state_d.failed) |->
    (result.status == utf8v_pkg::StInvalid))
    else $error("drain entered without an invalid verdict");

  a_pos_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.position <= utf8v_pkg::MaxRunBytes) &&
    (state_q.seq_start <= utf8v_pkg::MaxRunBytes))
    else $error("run offset beyond saturation limit");

endmodule

`default_nettype wire

>>> tb/utf8_stream_validator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_checker
// Watches the byte and result channels of the UTF-8 validator, predicts the
// verdict of every accepted byte and compares it with the result stream.
// ----------------------------------------------------------------------------

module utf8_stream_validator_checker
  import utf8v_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  utf8v_in_if         byte_bus,
  utf8v_out_if        result_bus,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // predictor copy of the run state and the mode register
  logic               zero_term;
  logic [1:0]         need;
  logic [7:0]         lead_b;
  logic [7:0]         byte2;
  logic [7:0]         byte3;
  logic [OffsetW-1:0] start_off;
  logic [OffsetW-1:0] pos;
  logic               draining;

  result_t            verdicts_q[$];
  int unsigned        fails;

  function automatic logic [OffsetW-1:0] offset_next(input logic [OffsetW-1:0] v);
    return (v >= MaxRunBytes) ? MaxRunBytes : v + 1'b1;
  endfunction

  function automatic void clear_run();
    need      = 2'd0;
    lead_b    = 8'h00;
    byte2     = 8'h00;
    byte3     = 8'h00;
    start_off = '0;
    pos       = '0;
    draining  = 1'b0;
  endfunction

  // is c an acceptable next byte of the open sequence
  function automatic logic tail_fits(input logic [7:0] c);
    logic fits;
    fits = (c[7:6] == 2'b10);
    if (fits && lead_b >= 8'hF0) begin
      if (need == 2'd3) begin
        if (lead_b == 8'hF0 && c < 8'h90) fits = 1'b0;
        if (lead_b == 8'hF4 && c > 8'h8F) fits = 1'b0;
      end else if (need == 2'd1) begin
        // last two code points of every plane
        if (c[7:1] == 7'h5F && byte3 == 8'hBF && (byte2 & 8'h8F) == 8'h8F) fits = 1'b0;
      end
    end else if (fits && lead_b >= 8'hE0) begin
      if (need == 2'd2) begin
        if (lead_b == 8'hE0 && c < 8'hA0) fits = 1'b0;
        if (lead_b == 8'hED && c > 8'h9F) fits = 1'b0;
      end else if (lead_b == 8'hEF) begin
        if (byte2 == 8'hB7 && c >= 8'h90 && c <= 8'hAF) fits = 1'b0;
        if (byte2 == 8'hBF && c[7:1] == 7'h5F) fits = 1'b0;
      end
    end
    return fits;
  endfunction

  function automatic result_t predict_byte(input logic [7:0] b, input logic last_flag);
    result_t r;
    logic    ends;
    logic    bad;
    ends         = zero_term ? (b == 8'h00) : last_flag;
    bad          = 1'b0;
    r.status     = StPending;
    r.end_offset = '0;
    if (draining) begin
      r.status = StDrain;
      if (ends) clear_run();
      else pos = offset_next(pos);
    end else begin
      if (need == 2'd0) begin
        start_off = pos;
        if (b == 8'h00) begin
          if (zero_term) begin
            r.status     = StValid;
            r.end_offset = pos;
          end else begin
            bad = 1'b1;
          end
        end else if (b < 8'h80) begin
          if (ends) begin
            r.status     = StValid;
            r.end_offset = offset_next(pos);
          end
        end else if (b < 8'hC2 || b > 8'hF4) begin
          bad = 1'b1;
        end else begin
          lead_b = b;
          byte2  = 8'h00;
          byte3  = 8'h00;
          need   = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
          if (ends) bad = 1'b1;
        end
      end else if (!tail_fits(b)) begin
        bad = 1'b1;
      end else begin
        if (lead_b >= 8'hF0) begin
          if (need == 2'd3) byte2 = b;
          else if (need == 2'd2) byte3 = b;
        end else if (lead_b >= 8'hE0 && need == 2'd2) begin
          byte2 = b;
        end
        need = need - 2'd1;
        if (ends) begin
          if (need != 2'd0) begin
            bad = 1'b1;
          end else begin
            r.status     = StValid;
            r.end_offset = offset_next(pos);
          end
        end
      end

      if (bad) begin
        r.status     = StInvalid;
        r.end_offset = start_off;
        if (ends) begin
          clear_run();
        end else begin
          draining = 1'b1;
          need     = 2'd0;
          pos      = offset_next(pos);
        end
      end else if (r.status == StValid) begin
        clear_run();
      end else begin
        pos = offset_next(pos);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      zero_term = 1'b0;
      clear_run();
      verdicts_q.delete();
      fails = 0;
    end else begin
      // a result never belongs to a byte taken at the same edge
      if (result_bus.valid && result_bus.ready) begin
        if (verdicts_q.size() == 0) begin
          fails++;
          $error("unexpected result transaction: status %0d end_offset %0d",
                 result_bus.status, result_bus.end_offset);
        end else begin
          want = verdicts_q.pop_front();
          if (result_bus.status !== want.status) begin
            fails++;
            $error("status: expected %0d, actual %0d", want.status, result_bus.status);
          end
          if (result_bus.end_offset !== want.end_offset) begin
            fails++;
            $error("end_offset: expected %0d, actual %0d",
                   want.end_offset, result_bus.end_offset);
          end
        end
      end
      if (cfg_we_i) zero_term = cfg_wdata_i;
      if (byte_bus.valid && byte_bus.ready)
        verdicts_q.push_back(predict_byte(byte_bus.data_byte, byte_bus.last_byte));
    end
    fail_count_o <= fails;
    pending_o    <= verdicts_q.size();
  end

endmodule

>>> tb/utf8_stream_validator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb
// Drives byte runs into the UTF-8 validator in both run modes: a directed
// set of boundary bytes, then random runs of encoded code points with broken
// sequences mixed in, under several sender/receiver idling mixes. The
// checker predicts every verdict.
// ----------------------------------------------------------------------------

module utf8_stream_validator_tb;
  import utf8v_pkg::*;

  localparam int unsigned CycleLimit   = 100_000;
  localparam int unsigned PartBytes    = 190;

  // {last_byte, data_byte}, bounded mode
  localparam logic [8:0] BoundedSeq [12] = '{
    {1'b0, 8'hFF}, {1'b1, 8'h41}, {1'b1, 8'hC1}, {1'b0, 8'hE0},
    {1'b0, 8'h9F}, {1'b1, 8'h00}, {1'b0, 8'hF4}, {1'b1, 8'h8F},
    {1'b0, 8'hC2}, {1'b0, 8'h80}, {1'b1, 8'h00}, {1'b0, 8'hE2}
  };
  // zero-terminated mode; the first two close the sequence left open above
  localparam logic [7:0] ZeroTermSeq [12] = '{
    8'h82, 8'hAC, 8'h00, 8'hEF, 8'hBF, 8'hBE,
    8'h41, 8'h00, 8'hC3, 8'h00, 8'h7F, 8'h00
  };

  localparam int unsigned IdleTab  [4] = '{0, 46, 0, 15};
  localparam int unsigned StallTab [4] = '{0, 0, 46, 15};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        cur_mode;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_cnt = 0;
  int unsigned fail_count;
  int unsigned pending_cnt;
  logic [7:0]  run_q[$];

  utf8v_in_if  in_bus ();
  utf8v_out_if out_bus ();

  utf8_stream_validator DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  utf8_stream_validator_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .byte_bus    (in_bus),
    .result_bus  (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last_flag);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last_flag;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic zt);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= zt;
    cur_mode  = zt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int unsigned pick_code(input logic regular_only);
    int unsigned sel;
    sel = regular_only ? $urandom_range(84) : $urandom_range(99);
    if (sel < 30) return $urandom_range(1, 32'h7F);
    if (sel < 45) return $urandom_range(32'h80, 32'h7FF);
    if (sel < 70) return $urandom_range(32'h800, 32'hFFFF);
    if (sel < 85) return $urandom_range(32'h10000, 32'h10FFFF);
    // noncharacters, surrogates and encoding-length boundaries
    case ($urandom_range(5))
      0: return 32'hFDCF + $urandom_range(33);
      1: return 32'hFFFC + $urandom_range(3);
      2: return ($urandom_range(1, 16) << 16) | (32'hFFFC + $urandom_range(3));
      3: return 32'hD7FF + $urandom_range(32'h801);
      4: return $urandom_range(32'h10FFF0, 32'h11000F);
      default: begin
        case ($urandom_range(4))
          0: return 32'h80;
          1: return 32'h7FF;
          2: return 32'h800;
          3: return 32'h10000;
          default: return 32'h3FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic push_code(input int unsigned cp);
    if (cp < 32'h80) begin
      run_q.push_back(8'(cp));
    end else if (cp < 32'h800) begin
      run_q.push_back(8'(32'hC0 | (cp >> 6)));
      run_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      run_q.push_back(8'(32'hE0 | (cp >> 12)));
      run_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      run_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      run_q.push_back(8'(32'hF0 | (cp >> 18)));
      run_q.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      run_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      run_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end
  endtask

  task automatic build_run();
    int unsigned n_chars;
    int unsigned pick;
    logic        clean;
    logic [7:0]  lead;
    run_q.delete();
    clean   = ($urandom_range(99) < 65);
    n_chars = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
    repeat (n_chars) begin
      pick = clean ? 99 : $urandom_range(99);
      if (pick < 4) begin
        run_q.push_back(8'($urandom_range(255)));
      end else if (pick < 7) begin
        run_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 12) begin
        // random tail after a lead with a second-byte or noncharacter limit
        case ($urandom_range(4))
          0: lead = 8'hE0;
          1: lead = 8'hED;
          2: lead = 8'hEF;
          3: lead = 8'hF0;
          default: lead = 8'hF4;
        endcase
        run_q.push_back(lead);
        repeat ((lead >= 8'hF0) ? 3 : 2) run_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        push_code(pick_code(clean));
      end
    end
    if (!clean && $urandom_range(3) == 0)
      run_q.push_back(8'($urandom_range(8'hC2, 8'hF4)));  // sequence cut short
    if (cur_mode) run_q.push_back(8'h00);
  endtask

  task automatic random_part(input int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      build_run();
      sent += run_q.size();
      for (int i = 0; i < run_q.size(); i++) begin
        if (cur_mode) send_byte(run_q[i], 1'($urandom_range(1)));
        else          send_byte(run_q[i], i == run_q.size() - 1);
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.last_byte <= 1'b0;
    cur_mode  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 12; i++) send_byte(BoundedSeq[i][7:0], BoundedSeq[i][8]);
    // switch modes with a three-byte sequence still open
    set_mode(1'b1);
    for (int i = 0; i < 12; i++) send_byte(ZeroTermSeq[i], 1'($urandom_range(1)));

    for (int p = 0; p < 4; p++) begin
      idle_pct  = IdleTab[p];
      stall_pct = StallTab[p];
      set_mode(1'b1);
      random_part(PartBytes);
      send_byte(8'hE2, 1'b0);
      set_mode(1'b0);
      random_part(PartBytes);
    end

    wait_drained();
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
